// ----- sv/u8u16_pkg.sv -----
// Package for the UTF-8 to UTF-16 name transcoder.
// Holds the result item type, status codes and code point constants.
// No dependencies; every other file of the block refers to it.
package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int TOTAL_W = 9;
    localparam int POINT_W = 21;
    localparam int LIMIT_W = 9;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [POINT_W-1:0] POINT_MAX     = 21'h10FFFF;
    localparam logic [POINT_W-1:0] SURR_FIRST    = 21'h00D800;
    localparam logic [POINT_W-1:0] SURR_LAST     = 21'h00DFFF;
    localparam logic [POINT_W-1:0] BMP_LAST      = 21'h00FFFF;
    localparam logic [POINT_W-1:0] SUPP_BASE     = 21'h010000;
    localparam logic [UNIT_W-1:0]  HIGH_SURR_TAG = 16'hD800;
    localparam logic [UNIT_W-1:0]  LOW_SURR_TAG  = 16'hDC00;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    // Configuration register indexes.
    localparam logic REG_NAME_LIMIT = 1'b0;

    typedef struct packed {
        logic [UNIT_W-1:0]  code_unit;
        logic               end_of_name;
        logic [1:0]         result_status;
        logic [TOTAL_W-1:0] unit_total;
    } result_t;

    // Zero, one or two results produced by one byte.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ----- sv/u8u16_byte_if.sv -----
// Byte channel of the UTF-8 to UTF-16 name transcoder.
// Carries one UTF-8 byte per transaction; uses u8u16_pkg for widths.
interface u8u16_byte_if;
    logic                         valid;
    logic                         ready;
    logic [u8u16_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// ----- sv/u8u16_unit_if.sv -----
// Result channel of the UTF-8 to UTF-16 name transcoder.
// Carries one UTF-16 unit or end-of-name status per transaction; uses u8u16_pkg.
interface u8u16_unit_if;
    logic                          valid;
    logic                          ready;
    logic [u8u16_pkg::UNIT_W-1:0]  code_unit;
    logic                          end_of_name;
    logic [1:0]                    result_status;
    logic [u8u16_pkg::TOTAL_W-1:0] unit_total;

    modport source (output valid, output code_unit, output end_of_name,
                    output result_status, output unit_total, input ready);
    modport sink (input valid, input code_unit, input end_of_name,
                  input result_status, input unit_total, output ready);
endinterface

// ----- sv/u8u16_decoder.sv -----
// UTF-8 decoder with running name state: validates bytes, rebuilds code points,
// checks the unit limit and produces up to two result items per byte.
// Depends on u8u16_pkg.
module u8u16_decoder #(
    parameter int MAX_UNITS = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [u8u16_pkg::BYTE_W-1:0]  data_byte,
    input  logic [u8u16_pkg::LIMIT_W-1:0] name_limit,
    output u8u16_pkg::push_t              push
);

    localparam int CNT_W = $clog2(MAX_UNITS + 1);
    localparam int CMP_W = ((CNT_W > u8u16_pkg::LIMIT_W) ? CNT_W : u8u16_pkg::LIMIT_W) + 2;
    localparam int EXT_W = CNT_W + u8u16_pkg::TOTAL_W + 1;

    logic [u8u16_pkg::POINT_W-1:0] partial_reg, partial_next;
    logic [1:0]                    pending_reg, pending_next;
    logic [CNT_W-1:0]              units_reg, units_next;
    logic [1:0]                    error_reg, error_next;

    logic [u8u16_pkg::POINT_W-1:0] cont_point;
    logic [u8u16_pkg::POINT_W-1:0] point;
    logic [u8u16_pkg::POINT_W-1:0] supp_offset;
    logic                          cont_ok;
    logic                          out_of_range;
    logic                          is_pair;
    logic [CMP_W-1:0]              limit_cap;
    logic [CMP_W-1:0]              needed;
    logic                          fits;
    logic [EXT_W-1:0]              total0_ext;
    logic [EXT_W-1:0]              total1_ext;
    logic [EXT_W-1:0]              total2_ext;
    u8u16_pkg::result_t            unit_a;
    u8u16_pkg::result_t            unit_b;
    u8u16_pkg::result_t            status_item;
    logic [1:0]                    status;

    always_comb
    begin
        cont_ok    = (data_byte[7:6] == 2'b10);
        cont_point = {partial_reg[u8u16_pkg::POINT_W-7:0], data_byte[5:0]};
        point      = (pending_reg != 2'd0) ? cont_point
                                           : u8u16_pkg::POINT_W'(data_byte);

        out_of_range = (point > u8u16_pkg::POINT_MAX) ||
                       ((point >= u8u16_pkg::SURR_FIRST) && (point <= u8u16_pkg::SURR_LAST));
        is_pair      = (point > u8u16_pkg::BMP_LAST);
        supp_offset  = point - u8u16_pkg::SUPP_BASE;

        if (CMP_W'(name_limit) > CMP_W'(MAX_UNITS))
        begin
            limit_cap = CMP_W'(MAX_UNITS);
        end
        else
        begin
            limit_cap = CMP_W'(name_limit);
        end
        needed = is_pair ? CMP_W'(2) : CMP_W'(1);
        fits   = (CMP_W'(units_reg) + needed) <= limit_cap;

        // Totals are reported modulo the width of the output field.
        total0_ext = EXT_W'(units_reg);
        total1_ext = EXT_W'(units_reg) + EXT_W'(1);
        total2_ext = EXT_W'(units_reg) + EXT_W'(2);

        unit_a.end_of_name   = 1'b0;
        unit_a.result_status = u8u16_pkg::ST_OK;
        unit_a.unit_total    = total1_ext[u8u16_pkg::TOTAL_W-1:0];
        unit_a.code_unit     = is_pair
            ? (u8u16_pkg::HIGH_SURR_TAG | u8u16_pkg::UNIT_W'(supp_offset[19:10]))
            : point[u8u16_pkg::UNIT_W-1:0];

        unit_b.end_of_name   = 1'b0;
        unit_b.result_status = u8u16_pkg::ST_OK;
        unit_b.unit_total    = total2_ext[u8u16_pkg::TOTAL_W-1:0];
        unit_b.code_unit     = u8u16_pkg::LOW_SURR_TAG | u8u16_pkg::UNIT_W'(supp_offset[9:0]);

        if (error_reg != u8u16_pkg::ST_OK)
        begin
            status = error_reg;
        end
        else if (pending_reg != 2'd0)
        begin
            status = u8u16_pkg::ST_BAD;
        end
        else if (units_reg == '0)
        begin
            status = u8u16_pkg::ST_EMPTY;
        end
        else
        begin
            status = u8u16_pkg::ST_OK;
        end
        status_item.code_unit     = '0;
        status_item.end_of_name   = 1'b1;
        status_item.result_status = status;
        status_item.unit_total    = total0_ext[u8u16_pkg::TOTAL_W-1:0];
    end

    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        units_next   = units_reg;
        error_next   = error_reg;
        push.count   = 2'd0;
        push.first   = unit_a;
        push.second  = unit_b;

        if (accept)
        begin
            if (data_byte == '0)
            begin
                push.count   = 2'd1;
                push.first   = status_item;
                partial_next = '0;
                pending_next = 2'd0;
                units_next   = '0;
                error_next   = u8u16_pkg::ST_OK;
            end
            else if (error_reg != u8u16_pkg::ST_OK)
            begin
                // Silent until the terminator once an error is latched.
            end
            else if ((pending_reg != 2'd0) && !cont_ok)
            begin
                error_next   = u8u16_pkg::ST_BAD;
                pending_next = 2'd0;
                partial_next = '0;
            end
            else if (pending_reg > 2'd1)
            begin
                partial_next = cont_point;
                pending_next = pending_reg - 2'd1;
            end
            else if ((pending_reg == 2'd1) || !data_byte[7])
            begin
                // A code point is complete: either the last continuation or ASCII.
                partial_next = '0;
                pending_next = 2'd0;
                if (out_of_range)
                begin
                    error_next = u8u16_pkg::ST_BAD;
                end
                else if (!fits)
                begin
                    error_next = u8u16_pkg::ST_LONG;
                end
                else if (is_pair)
                begin
                    push.count = 2'd2;
                    units_next = units_reg + CNT_W'(2);
                end
                else
                begin
                    push.count = 2'd1;
                    units_next = units_reg + CNT_W'(1);
                end
            end
            else if (data_byte[7:5] == 3'b110)
            begin
                partial_next = u8u16_pkg::POINT_W'(data_byte[4:0]);
                pending_next = 2'd1;
            end
            else if (data_byte[7:4] == 4'b1110)
            begin
                partial_next = u8u16_pkg::POINT_W'(data_byte[3:0]);
                pending_next = 2'd2;
            end
            else if (data_byte[7:3] == 5'b11110)
            begin
                partial_next = u8u16_pkg::POINT_W'(data_byte[2:0]);
                pending_next = 2'd3;
            end
            else
            begin
                error_next = u8u16_pkg::ST_BAD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= 2'd0;
            units_reg   <= '0;
            error_reg   <= u8u16_pkg::ST_OK;
        end
        else
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            units_reg   <= units_next;
            error_reg   <= error_next;
        end
    end

endmodule

// ----- sv/u8u16_result_fifo.sv -----
// Four-entry result queue: takes up to two items per cycle from the decoder
// and hands out one per cycle while out_ready is high. Depends on u8u16_pkg.
module u8u16_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  u8u16_pkg::push_t   push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output u8u16_pkg::result_t out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    u8u16_pkg::result_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;
    logic               pop;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign out_valid    = (count_reg != '0);
    assign out_item     = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    // Room for a surrogate pair is always kept, so a byte is never refused mid-pair.
    assign room         = (count_reg <= (PTR_W + 1)'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/utf8_to_utf16_name_transcoder_unit.sv -----
// Top level of the UTF-8 to UTF-16 name transcoder: APB register, decoder
// and result queue. Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if,
// u8u16_decoder and u8u16_result_fifo.
//
//   Channel    Dir   Payload                                          Flow
//   byte_in    in    data_byte[7:0]                                   valid/ready
//   unit_out   out   code_unit[15:0] end_of_name result_status[1:0]   valid/ready
//                    unit_total[8:0]
//   APB        in    name_limit at byte address 0                     psel/penable
//
// One byte per cycle is accepted while the queue has room. A byte's results enter the result queue at the
// clock edge that accepts it and can leave from the next cycle on.
// A surrogate pair leaves as two units, one unit per cycle on the output side while unit_out.ready is high.
// The input holds off only when the four-entry queue has fewer than two free slots.
// Reset clears the name state and the queue, and sets name_limit to 256.
module utf8_to_utf16_name_transcoder_unit #(
    parameter int MAX_UNITS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    u8u16_byte_if.sink          byte_in,
    u8u16_unit_if.source        unit_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [u8u16_pkg::LIMIT_W-1:0] name_limit_reg, name_limit_next;
    logic                          cfg_write;
    logic                          accept;
    logic                          room;
    u8u16_pkg::push_t              push;
    u8u16_pkg::result_t            out_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == u8u16_pkg::REG_NAME_LIMIT) ? 32'(name_limit_reg) : 32'd0;

    always_comb
    begin
        name_limit_next = name_limit_reg;
        if (cfg_write && (paddr[2] == u8u16_pkg::REG_NAME_LIMIT))
        begin
            name_limit_next = pwdata[u8u16_pkg::LIMIT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_limit_reg <= u8u16_pkg::LIMIT_RESET;
        end
        else
        begin
            name_limit_reg <= name_limit_next;
        end
    end

    assign byte_in.ready = room;
    assign accept        = byte_in.valid && room;

    u8u16_decoder #(
        .MAX_UNITS (MAX_UNITS)
    ) u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (byte_in.data_byte),
        .name_limit (name_limit_reg),
        .push       (push)
    );

    u8u16_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (unit_out.valid),
        .out_ready (unit_out.ready),
        .out_item  (out_item)
    );

    assign unit_out.code_unit     = out_item.code_unit;
    assign unit_out.end_of_name   = out_item.end_of_name;
    assign unit_out.result_status = out_item.result_status;
    assign unit_out.unit_total    = out_item.unit_total;

endmodule

// ----- tb/utf8_to_utf16_name_transcoder_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for utf8_to_utf16_name_transcoder_unit: streams UTF-8 names, predicts
// every UTF-16 unit and end-of-name status, and checks each result transaction.
// Depends on u8u16_pkg, u8u16_byte_if, u8u16_unit_if and the block's RTL.
module utf8_to_utf16_name_transcoder_unit_tb;

    typedef logic [u8u16_pkg::BYTE_W-1:0] byte_seq_t[$];

    localparam int NAME_CAP     = 256;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_GAP      = 11;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BYTES  = 130;

    localparam logic [2:0] LIMIT_ADDR = {u8u16_pkg::REG_NAME_LIMIT, 2'b00};

    localparam logic [u8u16_pkg::BYTE_W-1:0] NAME_END   = 8'h00;
    localparam logic [u8u16_pkg::BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [u8u16_pkg::BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [u8u16_pkg::BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [u8u16_pkg::BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [u8u16_pkg::BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [u8u16_pkg::BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [u8u16_pkg::BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [u8u16_pkg::BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

    localparam logic [u8u16_pkg::LIMIT_W-1:0] phase_cycle_limits[2] =
        '{u8u16_pkg::LIMIT_RESET, 9'd511};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    u8u16_byte_if byte_ch ();
    u8u16_unit_if unit_ch ();

    utf8_to_utf16_name_transcoder_unit #(
        .MAX_UNITS(NAME_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_in(byte_ch),
        .unit_out(unit_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Predictor state for the name being decoded.
    logic [u8u16_pkg::POINT_W-1:0] point_acc = '0;
    logic [1:0]                    cont_left = '0;
    int                            units_sent = 0;
    logic [1:0]                    first_error = u8u16_pkg::ST_OK;
    logic [u8u16_pkg::LIMIT_W-1:0] name_limit_reg = u8u16_pkg::LIMIT_RESET;

    u8u16_pkg::result_t units_due[$];
    byte_seq_t          name_bytes;

    bit gaps_on = 1'b0;
    int cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int names_done = 0;
    int bytes_sent = 0;
    int limit_writes = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, units_due.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int draw_wait();
        return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic void queue_unit(logic [u8u16_pkg::UNIT_W-1:0] unit, logic last,
                                       logic [1:0] status);
        u8u16_pkg::result_t r;
        r.code_unit     = unit;
        r.end_of_name   = last;
        r.result_status = status;
        r.unit_total    = u8u16_pkg::TOTAL_W'(units_sent);
        units_due = {units_due, r};
    endfunction

    function automatic void emit_point(logic [u8u16_pkg::POINT_W-1:0] cp);
        int                            lim;
        logic [u8u16_pkg::POINT_W-1:0] off;
        lim = (name_limit_reg > NAME_CAP) ? NAME_CAP : int'(name_limit_reg);
        if (cp > u8u16_pkg::POINT_MAX ||
            (cp >= u8u16_pkg::SURR_FIRST && cp <= u8u16_pkg::SURR_LAST))
            first_error = u8u16_pkg::ST_BAD;
        else if (cp <= u8u16_pkg::BMP_LAST)
        begin
            if (units_sent + 1 > lim)
                first_error = u8u16_pkg::ST_LONG;
            else
            begin
                units_sent++;
                queue_unit(cp[u8u16_pkg::UNIT_W-1:0], 1'b0, u8u16_pkg::ST_OK);
            end
        end
        else if (units_sent + 2 > lim)
            first_error = u8u16_pkg::ST_LONG;  // a pair never goes out as half a pair
        else
        begin
            off = cp - u8u16_pkg::SUPP_BASE;
            units_sent++;
            queue_unit(u8u16_pkg::HIGH_SURR_TAG | u8u16_pkg::UNIT_W'(off[19:10]), 1'b0,
                       u8u16_pkg::ST_OK);
            units_sent++;
            queue_unit(u8u16_pkg::LOW_SURR_TAG | u8u16_pkg::UNIT_W'(off[9:0]), 1'b0,
                       u8u16_pkg::ST_OK);
        end
    endfunction

    function automatic void decode_byte(logic [u8u16_pkg::BYTE_W-1:0] b);
        logic [1:0] status;
        if (b == NAME_END)
        begin
            if (first_error != u8u16_pkg::ST_OK)
                status = first_error;
            else if (cont_left != 0)
                status = u8u16_pkg::ST_BAD;
            else if (units_sent == 0)
                status = u8u16_pkg::ST_EMPTY;
            else
                status = u8u16_pkg::ST_OK;
            queue_unit('0, 1'b1, status);
            point_acc   = '0;
            cont_left   = '0;
            units_sent  = 0;
            first_error = u8u16_pkg::ST_OK;
        end
        else if (first_error == u8u16_pkg::ST_OK)
        begin
            // Once an error is latched, bytes are dropped until the terminator.
            if (cont_left != 0)
            begin
                if ((b & CONT_MASK) != CONT_TAG)
                begin
                    first_error = u8u16_pkg::ST_BAD;
                    cont_left   = '0;
                    point_acc   = '0;
                end
                else
                begin
                    point_acc = {point_acc[u8u16_pkg::POINT_W-7:0], b[5:0]};
                    cont_left--;
                    if (cont_left == 0)
                    begin
                        emit_point(point_acc);
                        point_acc = '0;
                    end
                end
            end
            else if (!b[7])
                emit_point(u8u16_pkg::POINT_W'(b));
            else if ((b & LEAD2_MASK) == LEAD2_TAG)
            begin
                point_acc = u8u16_pkg::POINT_W'(b[4:0]);
                cont_left = 2'd1;
            end
            else if ((b & LEAD3_MASK) == LEAD3_TAG)
            begin
                point_acc = u8u16_pkg::POINT_W'(b[3:0]);
                cont_left = 2'd2;
            end
            else if ((b & LEAD4_MASK) == LEAD4_TAG)
            begin
                point_acc = u8u16_pkg::POINT_W'(b[2:0]);
                cont_left = 2'd3;
            end
            else
                first_error = u8u16_pkg::ST_BAD;
        end
    endfunction

    // Valid stays high after a transaction so a back-to-back byte needs no toggle.
    task automatic send_byte(input logic [u8u16_pkg::BYTE_W-1:0] b);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_name(input byte_seq_t seq);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (units_due.size() != 0)
            @(posedge clk);
        // Bytes that make no result may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_name_limit(input logic [u8u16_pkg::LIMIT_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        name_limit_reg = value;
        limit_writes++;
        @(posedge clk);
    endtask

    function automatic void append_char(int len);
        case (len)
            1: name_bytes = {name_bytes, 8'($urandom_range(1, 127))};
            2: name_bytes = {name_bytes, {3'b110, 5'($urandom)}};
            3: name_bytes = {name_bytes, {4'b1110, 4'($urandom)}};
            // Leads above F4 are always out of range, so they come only now and then.
            default: name_bytes = {name_bytes, {5'b11110, 3'(($urandom_range(0, 15) == 0) ?
                                   $urandom_range(5, 7) : $urandom_range(0, 4))}};
        endcase
        repeat (len - 1) name_bytes = {name_bytes, {2'b10, 6'($urandom)}};
    endfunction

    function automatic void build_random_name();
        int pick;
        name_bytes.delete();
        repeat ($urandom_range(0, 9))
        begin
            pick = $urandom_range(0, 9);
            append_char(pick < 4 ? 1 : pick < 6 ? 2 : pick < 8 ? 3 : 4);
        end
        if ($urandom_range(0, 7) == 0)
            name_bytes.insert($urandom_range(0, name_bytes.size()),
                              8'($urandom_range(1, 255)));
        if ($urandom_range(0, 15) == 0 && name_bytes.size() != 0)
            name_bytes.delete(name_bytes.size() - 1);
        name_bytes = {name_bytes, NAME_END};
    endfunction

    task automatic test_valid_forms();
        gaps_on = 1'b0;
        send_name('{NAME_END});
        send_name('{8'h01, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                    8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F, NAME_END});
        wait_drained();
    endtask

    task automatic test_encoding_errors();
        gaps_on = 1'b1;
        send_name('{8'h80, 8'h41, NAME_END});
        // Units before the bad lead stay emitted; the valid two-byte character after it is dropped.
        send_name('{8'h41, 8'hF8, 8'hC2, 8'h80, NAME_END});
        send_name('{8'hC3, 8'h41, NAME_END});
        send_name('{8'hE2, 8'h82, NAME_END});
        send_name('{8'hED, 8'hA0, 8'h80, NAME_END});
        send_name('{8'hF4, 8'h90, 8'h80, 8'h80, NAME_END});
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        gaps_on = 1'b1;
        write_name_limit(9'd1);
        send_name('{8'hF0, 8'h90, 8'h80, 8'h80, 8'h41, NAME_END});
        send_name('{8'h41, NAME_END});
        write_name_limit(9'd0);
        send_name('{8'h41, NAME_END});
        send_name('{NAME_END});
    endtask

    task automatic test_random_names();
        int phase_limits[7];
        int start;
        phase_limits = '{2, 8, 256, 0, 1, 0, 511};
        phase_limits[5] = $urandom_range(1, NAME_CAP);
        foreach (phase_limits[i])
        begin
            write_name_limit(u8u16_pkg::LIMIT_W'(phase_limits[i]));
            gaps_on = ($urandom_range(0, 3) != 0);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) == 0)
                    gaps_on = !gaps_on;
                build_random_name();
                send_name(name_bytes);
            end
        end
    endtask

    // Names that end right around the limit, once at the cap and once above it.
    task automatic test_long_names();
        int target;
        int units;
        foreach (phase_cycle_limits[i])
        begin
            write_name_limit(phase_cycle_limits[i]);
            gaps_on = ($urandom_range(0, 1) != 0);
            target = $urandom_range(NAME_CAP - 6, NAME_CAP + 6);
            units = 0;
            name_bytes.delete();
            while (units < target)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    name_bytes = {name_bytes, 8'hF0, {4'b1001, 4'($urandom)},
                                  {2'b10, 6'($urandom)}, {2'b10, 6'($urandom)}};
                    units += 2;
                end
                else
                begin
                    name_bytes = {name_bytes, 8'($urandom_range(1, 127))};
                    units++;
                end
            end
            name_bytes = {name_bytes, NAME_END};
            send_name(name_bytes);
        end
    endtask

    task automatic check_result(input u8u16_pkg::result_t got);
        u8u16_pkg::result_t want;
        if (units_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0d] unexpected result: unit %h end %b status %0d total %0d",
                         cycle_count, got.code_unit, got.end_of_name,
                         got.result_status, got.unit_total);
        end
        else
        begin
            want = units_due.pop_front();
            results_checked++;
            if (want.end_of_name)
                names_done++;
            if (got.code_unit !== want.code_unit || got.end_of_name !== want.end_of_name ||
                got.result_status !== want.result_status ||
                got.unit_total !== want.unit_total)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0d] expected %h/%b/%0d/%0d, got %h/%b/%0d/%0d",
                             cycle_count, want.code_unit, want.end_of_name,
                             want.result_status, want.unit_total, got.code_unit,
                             got.end_of_name, got.result_status, got.unit_total);
            end
        end
    endtask

    initial
    begin : result_sink
        int                 stall;
        u8u16_pkg::result_t got;
        unit_ch.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                unit_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            unit_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!unit_ch.valid);
            got.code_unit     = unit_ch.code_unit;
            got.end_of_name   = unit_ch.end_of_name;
            got.result_status = unit_ch.result_status;
            got.unit_total    = unit_ch.unit_total;
            check_result(got);
        end
    end

    initial
    begin
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_valid_forms();
        test_encoding_errors();
        test_limit_extremes();
        test_random_names();
        test_long_names();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Streamed %0d bytes in %0d names under %0d name_limit settings,",
                 bytes_sent, names_done, limit_writes);
        $display("with bad leads, broken sequences, surrogates, limit edges; %0d checked.",
                 results_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
